// File: rtl/ocs_pkg.sv
// Shared types, codes and small lookup functions for the operator console sequencer.
// Used by ocs_core, ocs_decode and operator_console_sequencer; no dependencies.
`default_nettype none

package ocs_pkg;

  localparam int WORD_DIGITS  = 10;
  localparam int ENTRY_DIGITS = (WORD_DIGITS < 10) ? WORD_DIGITS : 10;

  localparam int IN_W  = 56;
  localparam int OUT_W = 56;

  // Digit times.
  localparam logic [3:0] DT_SIGN = 4'd0;
  localparam logic [3:0] DT_TEN  = 4'd10;
  localparam logic [3:0] DT_GAP  = 4'd11;

  // Console command codes.
  localparam logic [4:0] CMD_NONE      = 5'd0;
  localparam logic [4:0] CMD_SW_PGM    = 5'd1;
  localparam logic [4:0] CMD_SW_HALF   = 5'd2;
  localparam logic [4:0] CMD_SW_CTRL   = 5'd3;
  localparam logic [4:0] CMD_SW_DISP   = 5'd4;
  localparam logic [4:0] CMD_SW_OVFL   = 5'd5;
  localparam logic [4:0] CMD_SW_ERR    = 5'd6;
  localparam logic [4:0] CMD_ENTRY     = 5'd7;
  localparam logic [4:0] CMD_ADDR      = 5'd8;
  localparam logic [4:0] CMD_XFER_KEY  = 5'd9;
  localparam logic [4:0] CMD_START_KEY = 5'd10;
  localparam logic [4:0] CMD_STOP_KEY  = 5'd11;
  localparam logic [4:0] CMD_PGM_RST   = 5'd12;
  localparam logic [4:0] CMD_COMP_RST  = 5'd13;
  localparam logic [4:0] CMD_ACC_RST   = 5'd14;
  localparam logic [4:0] CMD_ERR_RST   = 5'd15;
  localparam logic [4:0] CMD_ESR_RST   = 5'd16;
  localparam logic [4:0] CMD_CONSOLE   = 5'd17;

  // Pending flag bits.
  localparam int FL_POWER   = 0;
  localparam int FL_CONSOLE = 1;
  localparam int FL_PGM     = 2;
  localparam int FL_ACC     = 3;
  localparam int FL_ERR     = 4;
  localparam int FL_ESR     = 5;

  // Line register bits.
  localparam int LN_BUSY  = 0;
  localparam int LN_ERR   = 1;
  localparam int LN_ESR   = 2;
  localparam int LN_PGM   = 3;
  localparam int LN_ACC   = 4;
  localparam int LN_S8000 = 5;
  localparam int LN_R0000 = 6;
  localparam int LN_START = 7;
  localparam int LN_XFER  = 8;

  // Sequencer state codes.
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_PGM  = 5'd1;
  localparam logic [4:0] ST_ACC  = 5'd4;
  localparam logic [4:0] ST_ERR  = 5'd7;
  localparam logic [4:0] ST_ESR  = 5'd10;
  localparam logic [4:0] ST_XK1  = 5'd13;
  localparam logic [4:0] ST_XK2  = 5'd14;
  localparam logic [4:0] ST_PS   = 5'd15;
  localparam logic [4:0] ST_LAST = 5'd17;

  // Sequence groups.
  localparam logic [2:0] GRP_PGM   = 3'd0;
  localparam logic [2:0] GRP_ACC   = 3'd1;
  localparam logic [2:0] GRP_ERR   = 3'd2;
  localparam logic [2:0] GRP_ESR   = 3'd3;
  localparam logic [2:0] GRP_START = 3'd4;

  // Control switch positions.
  localparam logic [1:0] CTRL_ADDR_STOP = 2'd0;
  localparam logic [1:0] CTRL_RUN       = 2'd1;
  localparam logic [1:0] CTRL_MANUAL    = 2'd2;

  localparam logic [8:0]  SW_RESET   = 9'h012;
  localparam logic [15:0] ADDR_RESET = 16'h8000;

  // Console state as seen after one digit time.
  typedef struct packed {
    logic [8:0]  lines;
    logic [8:0]  sw;
    logic [15:0] addr;
    logic [40:0] entry;
  } ocs_view_t;

  typedef struct packed {
    logic [2:0] grp;
    logic [1:0] stage;
  } ocs_seq_pos_t;

  // Splits a sequence state into its group and the stage within it.
  function automatic ocs_seq_pos_t seq_pos(input logic [4:0] s);
    ocs_seq_pos_t p;
    unique case (s)
      5'd1:    p = '{GRP_PGM,   2'd0};
      5'd2:    p = '{GRP_PGM,   2'd1};
      5'd3:    p = '{GRP_PGM,   2'd2};
      5'd4:    p = '{GRP_ACC,   2'd0};
      5'd5:    p = '{GRP_ACC,   2'd1};
      5'd6:    p = '{GRP_ACC,   2'd2};
      5'd7:    p = '{GRP_ERR,   2'd0};
      5'd8:    p = '{GRP_ERR,   2'd1};
      5'd9:    p = '{GRP_ERR,   2'd2};
      5'd10:   p = '{GRP_ESR,   2'd0};
      5'd11:   p = '{GRP_ESR,   2'd1};
      5'd12:   p = '{GRP_ESR,   2'd2};
      5'd15:   p = '{GRP_START, 2'd0};
      5'd16:   p = '{GRP_START, 2'd1};
      5'd17:   p = '{GRP_START, 2'd2};
      default: p = '{GRP_START, 2'd2};
    endcase
    return p;
  endfunction

  // Line register bit driven by each sequence group.
  function automatic logic [3:0] seq_line(input logic [2:0] g);
    logic [3:0] b;
    unique case (g)
      GRP_PGM: b = 4'(LN_PGM);
      GRP_ACC: b = 4'(LN_ACC);
      GRP_ERR: b = 4'(LN_ERR);
      GRP_ESR: b = 4'(LN_ESR);
      default: b = 4'(LN_START);
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/operator_console_sequencer.sv
// Operator console sequencer, top level: stream ports, result register, assertions.
// The result item of an accepted input item is registered and shows on out_tvalid in the next cycle.
// Throughput: one item per cycle unless out_tready holds a full result register; state and result update together.
// A full result register still accepts an item when out_tready is high in that cycle.
// Reset (rst_n low, synchronous): power-on flag pending, busy set, switches at reset.
// Depends on ocs_pkg, ocs_core and ocs_decode.
`default_nettype none

module operator_console_sequencer
  import ocs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // [3:0] digit_time, [4] upper_wd, [5] restart_lvl, [10:6] command,
  // [13:11] switch_setting, [53:14] operand_digits, [54] operand_sign
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // [0] busy_res, [6:1] reset_lines, [7] program_start, [8] transfer_pulse,
  // [29:9] switch_lines, [45:30] address_switch_digits, [49:46] entry_digit
  output logic [OUT_W-1:0]      out_tdata
);

  logic             accept;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  ocs_view_t        view_nxt;

  logic        busy_res, program_start, transfer_pulse;
  logic [5:0]  reset_lines;
  logic [20:0] switch_lines;
  logic [15:0] address_switch_digits;
  logic [3:0]  entry_digit;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  ocs_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (accept),
    .digit_time     (in_tdata[3:0]),
    .upper_wd       (in_tdata[4]),
    .restart_lvl    (in_tdata[5]),
    .command        (in_tdata[10:6]),
    .switch_setting (in_tdata[13:11]),
    .operand_digits (in_tdata[53:14]),
    .operand_sign   (in_tdata[54]),
    .view_nxt       (view_nxt)
  );

  ocs_decode u_decode (
    .view                  (view_nxt),
    .digit_time            (in_tdata[3:0]),
    .busy_res              (busy_res),
    .reset_lines           (reset_lines),
    .program_start         (program_start),
    .transfer_pulse        (transfer_pulse),
    .switch_lines          (switch_lines),
    .address_switch_digits (address_switch_digits),
    .entry_digit           (entry_digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {6'd0, entry_digit, address_switch_digits, switch_lines,
                     transfer_pulse, program_start, reset_lines, busy_res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An accepted item always leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted item produced no result");

  // A command is latched only from an idle console with every line dropped.
  a_latch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[8:1] == 8'd0)
    else $error("command latched while a line was active");

  // The program reset sequence raises either set 8000 or reset 0000, never both.
  a_pgm_line_choice: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones(out_tdata[6:5]) <= 1)
    else $error("set 8000 and reset 0000 raised together");

  // The transfer pulse never overlaps a reset or start sequence.
  a_xfer_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[7:1] == 7'd0)
    else $error("transfer pulse overlaps another sequence");

endmodule

`default_nettype wire

// File: rtl/ocs_core.sv
// Console state registers and the next-state logic for one digit time.
// Depends on ocs_pkg; gives the post-step view to ocs_decode.
`default_nettype none

module ocs_core
  import ocs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [3:0]  digit_time,
  input  wire logic        upper_wd,
  input  wire logic        restart_lvl,
  input  wire logic [4:0]  command,
  input  wire logic [2:0]  switch_setting,
  input  wire logic [39:0] operand_digits,
  input  wire logic        operand_sign,
  output ocs_view_t        view_nxt
);

  logic [4:0]  seq_r,   seq_nxt;
  logic [4:0]  acmd_r,  acmd_nxt;
  logic [4:0]  qcmd_r,  qcmd_nxt;
  logic [2:0]  aset_r,  aset_nxt;
  logic [2:0]  qset_r,  qset_nxt;
  logic [40:0] aopd_r,  aopd_nxt;
  logic [40:0] qopd_r,  qopd_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic [8:0]  sw_r,    sw_nxt;
  logic [40:0] entry_r, entry_nxt;
  logic [15:0] addr_r,  addr_nxt;
  logic [8:0]  lines_r, lines_nxt;

  ocs_seq_pos_t pos;
  logic [3:0]   lbit;

  assign pos  = seq_pos(seq_r);
  assign lbit = seq_line(pos.grp);

  always_comb begin
    seq_nxt   = seq_r;
    acmd_nxt  = acmd_r;
    qcmd_nxt  = qcmd_r;
    aset_nxt  = aset_r;
    qset_nxt  = qset_r;
    aopd_nxt  = aopd_r;
    qopd_nxt  = qopd_r;
    flags_nxt = flags_r;
    sw_nxt    = sw_r;
    entry_nxt = entry_r;
    addr_nxt  = addr_r;
    lines_nxt = lines_r;

    if (seq_r == ST_IDLE) begin
      lines_nxt[LN_BUSY] = 1'b1;
      if (acmd_r == CMD_NONE) begin
        // Restart reset outranks every pending flag and blocks the latch.
        priority if (restart_lvl) begin
          flags_nxt[FL_PGM] = 1'b1;
          flags_nxt[FL_ACC] = 1'b1;
          flags_nxt[FL_ERR] = 1'b1;
        end else if (flags_r[FL_POWER]) begin
          flags_nxt = flags_r | 6'b111110;
          flags_nxt[FL_POWER] = 1'b0;
        end else if (flags_r[FL_CONSOLE]) begin
          flags_nxt[FL_CONSOLE] = 1'b0;
          sw_nxt    = SW_RESET;
          entry_nxt = '0;
          addr_nxt  = ADDR_RESET;
        end else if (flags_r[FL_PGM]) begin
          flags_nxt[FL_PGM] = 1'b0;
          seq_nxt = ST_PGM;
        end else if (flags_r[FL_ACC]) begin
          flags_nxt[FL_ACC] = 1'b0;
          seq_nxt = ST_ACC;
        end else if (flags_r[FL_ERR]) begin
          flags_nxt[FL_ERR] = 1'b0;
          seq_nxt = ST_ERR;
        end else if (flags_r[FL_ESR]) begin
          flags_nxt[FL_ESR] = 1'b0;
          seq_nxt = ST_ESR;
        end else begin
          acmd_nxt = qcmd_r;
          aset_nxt = qset_r;
          aopd_nxt = qopd_r;
          qcmd_nxt = command;
          qset_nxt = switch_setting;
          qopd_nxt = {operand_sign, operand_digits};
          lines_nxt[LN_BUSY] = 1'b0;
        end
      end else begin
        acmd_nxt = CMD_NONE;
        unique case (acmd_r)
          CMD_SW_PGM:    if (aset_r <= 3'd1) sw_nxt[0] = aset_r[0];
          CMD_SW_HALF:   if (aset_r <= 3'd1) sw_nxt[1] = aset_r[0];
          CMD_SW_CTRL:   if (aset_r <= 3'd2) sw_nxt[3:2] = aset_r[1:0];
          CMD_SW_DISP:   if (aset_r <= 3'd5) sw_nxt[6:4] = aset_r;
          CMD_SW_OVFL:   if (aset_r <= 3'd1) sw_nxt[7] = aset_r[0];
          CMD_SW_ERR:    if (aset_r <= 3'd1) sw_nxt[8] = aset_r[0];
          CMD_ENTRY:     entry_nxt = aopd_r;
          CMD_ADDR:      addr_nxt = aopd_r[15:0];
          CMD_XFER_KEY:  if (sw_r[3:2] == CTRL_MANUAL) seq_nxt = ST_XK1;
          CMD_START_KEY: seq_nxt = ST_PS;
          CMD_PGM_RST:   flags_nxt[FL_PGM] = 1'b1;
          CMD_COMP_RST: begin
            flags_nxt[FL_PGM] = 1'b1;
            flags_nxt[FL_ACC] = 1'b1;
            flags_nxt[FL_ERR] = 1'b1;
          end
          CMD_ACC_RST:   flags_nxt[FL_ACC] = 1'b1;
          CMD_ERR_RST:   flags_nxt[FL_ERR] = 1'b1;
          CMD_ESR_RST:   flags_nxt[FL_ESR] = 1'b1;
          CMD_CONSOLE:   flags_nxt[FL_CONSOLE] = 1'b1;
          // The program stop key and unused codes are dropped.
          default: ;
        endcase
      end
    end else if (seq_r == ST_XK1) begin
      lines_nxt[LN_XFER] = 1'b1;
      seq_nxt = ST_XK2;
    end else if (seq_r == ST_XK2) begin
      lines_nxt[LN_XFER] = 1'b0;
      seq_nxt = ST_IDLE;
    end else if (seq_r > ST_LAST) begin
      seq_nxt = ST_IDLE;
    end else begin
      unique case (pos.stage)
        2'd0: begin
          if (digit_time == DT_TEN && upper_wd) begin
            lines_nxt[lbit] = 1'b1;
            if (pos.grp == GRP_PGM) begin
              if (sw_r[3:2] == CTRL_ADDR_STOP || sw_r[3:2] == CTRL_RUN) begin
                lines_nxt[LN_S8000] = 1'b1;
              end else begin
                lines_nxt[LN_R0000] = 1'b1;
              end
            end
            seq_nxt = seq_r + 5'd1;
          end
        end
        2'd1: begin
          if (digit_time == DT_GAP && !upper_wd) seq_nxt = seq_r + 5'd1;
        end
        default: begin
          // Program and accumulator resets end only at x of the lower word.
          if (digit_time == DT_GAP &&
              (!(pos.grp == GRP_PGM || pos.grp == GRP_ACC) || !upper_wd)) begin
            lines_nxt[lbit] = 1'b0;
            if (pos.grp == GRP_PGM) begin
              lines_nxt[LN_S8000] = 1'b0;
              lines_nxt[LN_R0000] = 1'b0;
            end
            seq_nxt = ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= ST_IDLE;
      acmd_r  <= CMD_NONE;
      qcmd_r  <= CMD_NONE;
      aset_r  <= '0;
      qset_r  <= '0;
      aopd_r  <= '0;
      qopd_r  <= '0;
      flags_r <= 6'(1 << FL_POWER);
      sw_r    <= SW_RESET;
      entry_r <= '0;
      addr_r  <= ADDR_RESET;
      lines_r <= 9'(1 << LN_BUSY);
    end else if (step) begin
      seq_r   <= seq_nxt;
      acmd_r  <= acmd_nxt;
      qcmd_r  <= qcmd_nxt;
      aset_r  <= aset_nxt;
      qset_r  <= qset_nxt;
      aopd_r  <= aopd_nxt;
      qopd_r  <= qopd_nxt;
      flags_r <= flags_nxt;
      sw_r    <= sw_nxt;
      entry_r <= entry_nxt;
      addr_r  <= addr_nxt;
      lines_r <= lines_nxt;
    end
  end

  assign view_nxt = '{lines: lines_nxt, sw: sw_nxt, addr: addr_nxt, entry: entry_nxt};

endmodule

`default_nettype wire

// File: rtl/ocs_decode.sv
// Output decode: switch one-hot lines, reset line packing and the entry digit.
// Depends on ocs_pkg; fed by ocs_core with the state after the current step.
`default_nettype none

module ocs_decode
  import ocs_pkg::*;
(
  input  wire ocs_view_t   view,
  input  wire logic [3:0]  digit_time,
  output logic             busy_res,
  output logic [5:0]       reset_lines,
  output logic             program_start,
  output logic             transfer_pulse,
  output logic [20:0]      switch_lines,
  output logic [15:0]      address_switch_digits,
  output logic [3:0]       entry_digit
);

  logic       p, h, o, e;
  logic [1:0] c;
  logic [2:0] d;

  assign p = view.sw[0];
  assign h = view.sw[1];
  assign c = view.sw[3:2];
  assign d = view.sw[6:4];
  assign o = view.sw[7];
  assign e = view.sw[8];

  assign busy_res       = view.lines[LN_BUSY];
  assign reset_lines    = {view.lines[LN_R0000], view.lines[LN_S8000], view.lines[LN_ACC],
                           view.lines[LN_PGM], view.lines[LN_ESR], view.lines[LN_ERR]};
  assign program_start  = view.lines[LN_START];
  assign transfer_pulse = view.lines[LN_XFER];
  assign address_switch_digits = view.addr;

  always_comb begin
    switch_lines     = '0;
    switch_lines[0]  = !p;
    switch_lines[1]  = p;
    switch_lines[2]  = !h;
    switch_lines[3]  = h;
    switch_lines[4]  = (c == CTRL_ADDR_STOP);
    switch_lines[5]  = (c == CTRL_RUN);
    switch_lines[6]  = (c == CTRL_MANUAL);
    switch_lines[7]  = !o;
    switch_lines[8]  = o;
    switch_lines[9]  = !e;
    switch_lines[10] = e;
    switch_lines[11] = (d == 3'd0);
    switch_lines[12] = (d == 3'd1);
    switch_lines[13] = (d == 3'd2);
    switch_lines[14] = (d == 3'd3);
    switch_lines[15] = (d == 3'd4);
    switch_lines[16] = (d == 3'd5);
    switch_lines[17] = (d == 3'd4);
    switch_lines[18] = (d == 3'd5);
    switch_lines[19] = (d != 3'd4);
    switch_lines[20] = (d <= 3'd3);
  end

  always_comb begin
    entry_digit = '0;
    if (digit_time == DT_SIGN) begin
      entry_digit = {3'b000, view.entry[40]};
    end else begin
      for (int i = 1; i <= ENTRY_DIGITS; i++) begin
        if (digit_time == 4'(i)) entry_digit = view.entry[4*(i-1) +: 4];
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/operator_console_sequencer_test.sv
// Self-checking testbench for operator_console_sequencer: drum-timed console commands in,
// console line and switch views out, each compared with an in-bench console model.
// Depends on ocs_pkg and the operator_console_sequencer RTL.

module operator_console_sequencer_test;
  import ocs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  // Switch settings and a command code the console does not know.
  localparam logic [2:0] SET_OFF       = 3'd0;
  localparam logic [2:0] SET_ON        = 3'd1;
  localparam logic [2:0] SET_CTRL_BAD  = 3'd3;
  localparam logic [2:0] SET_BAD       = 3'd7;
  localparam logic [2:0] DISP_PGM_REG  = 3'd3;
  localparam logic [2:0] DISP_READ_IN  = 3'd4;
  localparam logic [2:0] DISP_READ_OUT = 3'd5;
  localparam logic [4:0] CMD_UNUSED    = 5'd31;

  typedef struct packed {
    logic        pad;
    logic        sign;
    logic [39:0] opd;
    logic [2:0]  setting;
    logic [4:0]  cmd;
    logic        restart;
    logic        upper;
    logic [3:0]  dt;
  } console_item_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [3:0]  digit;
    logic [15:0] addr;
    logic [20:0] sw;
    logic        xfer;
    logic        start;
    logic [5:0]  rst;
    logic        busy;
  } console_view_t;

  typedef struct packed {
    logic          wait_rdy;
    logic          drum;
    logic          typed;
    console_item_t item;
    console_view_t view;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  operator_console_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Console model state.
  logic [4:0]  seq_st;
  logic [4:0]  act_cmd;
  logic [4:0]  q_cmd;
  logic [2:0]  act_set;
  logic [2:0]  q_set;
  logic [40:0] act_opd;
  logic [40:0] q_opd;
  logic [5:0]  flags;
  logic [8:0]  sw_pos;
  logic [40:0] entry_w;
  logic [15:0] addr_sel;
  logic [8:0]  lines;

  console_view_t views_due[$];
  dir_row_t      dir_rows[$];

  logic [3:0]  drum_dt = DT_SIGN;
  logic        drum_upper = 1'b0;
  int unsigned burst_left = 1;
  int unsigned items_sent = 0;
  int unsigned views_checked = 0;
  int unsigned cmds_run = 0;
  int unsigned seqs_done = 0;
  int unsigned fails = 0;
  int unsigned quiet = 0;
  int unsigned rx_cyc = 0;
  int unsigned rx_stall = 0;

  task automatic console_power_on();
    sw_pos   = SW_RESET;
    entry_w  = '0;
    addr_sel = ADDR_RESET;
    seq_st   = ST_IDLE;
    act_cmd  = CMD_NONE;
    q_cmd    = CMD_NONE;
    act_set  = '0;
    q_set    = '0;
    act_opd  = '0;
    q_opd    = '0;
    flags    = '0;
    flags[FL_POWER] = 1'b1;
    lines    = '0;
    lines[LN_BUSY] = 1'b1;
  endtask

  function automatic bit console_idle();
    return seq_st == ST_IDLE && flags == '0 && act_cmd == CMD_NONE;
  endfunction

  // Advances the console by one digit time and returns what it shows afterwards.
  task automatic console_step(input console_item_t it, output console_view_t v);
    logic [4:0] cmd;
    logic [2:0] grp;
    logic [4:0] base;
    logic [1:0] stage;
    logic [2:0] dsp;
    logic [1:0] ctl;
    int         ln;
    bit         lower_end;
    if (seq_st == ST_IDLE) begin
      lines[LN_BUSY] = 1'b1;
      cmd = act_cmd;
      if (cmd == CMD_NONE) begin
        if (it.restart) begin
          flags[FL_PGM] = 1'b1;
          flags[FL_ACC] = 1'b1;
          flags[FL_ERR] = 1'b1;
        end else if (flags[FL_POWER]) begin
          flags[FL_POWER]   = 1'b0;
          flags[FL_CONSOLE] = 1'b1;
          flags[FL_ERR]     = 1'b1;
          flags[FL_ESR]     = 1'b1;
          flags[FL_PGM]     = 1'b1;
          flags[FL_ACC]     = 1'b1;
        end else if (flags[FL_CONSOLE]) begin
          flags[FL_CONSOLE] = 1'b0;
          sw_pos   = SW_RESET;
          entry_w  = '0;
          addr_sel = ADDR_RESET;
        end else if (flags[FL_PGM]) begin
          flags[FL_PGM] = 1'b0;
          seq_st = ST_PGM;
        end else if (flags[FL_ACC]) begin
          flags[FL_ACC] = 1'b0;
          seq_st = ST_ACC;
        end else if (flags[FL_ERR]) begin
          flags[FL_ERR] = 1'b0;
          seq_st = ST_ERR;
        end else if (flags[FL_ESR]) begin
          flags[FL_ESR] = 1'b0;
          seq_st = ST_ESR;
        end else begin
          // Two-stage latch: the queued command moves up, the new one is sampled.
          act_cmd = q_cmd;
          act_set = q_set;
          act_opd = q_opd;
          q_cmd   = it.cmd;
          q_set   = it.setting;
          q_opd   = {it.sign, it.opd};
          lines[LN_BUSY] = 1'b0;
        end
      end else begin
        act_cmd = CMD_NONE;
        cmds_run++;
        case (cmd)
          CMD_SW_PGM:    if (act_set <= SET_ON) sw_pos[0] = act_set[0];
          CMD_SW_HALF:   if (act_set <= SET_ON) sw_pos[1] = act_set[0];
          CMD_SW_CTRL:   if (act_set <= 3'(CTRL_MANUAL)) sw_pos[3:2] = act_set[1:0];
          CMD_SW_DISP:   if (act_set <= DISP_READ_OUT) sw_pos[6:4] = act_set;
          CMD_SW_OVFL:   if (act_set <= SET_ON) sw_pos[7] = act_set[0];
          CMD_SW_ERR:    if (act_set <= SET_ON) sw_pos[8] = act_set[0];
          CMD_ENTRY:     entry_w = act_opd;
          CMD_ADDR:      addr_sel = act_opd[15:0];
          CMD_XFER_KEY:  if (sw_pos[3:2] == CTRL_MANUAL) seq_st = ST_XK1;
          CMD_START_KEY: seq_st = ST_PS;
          CMD_PGM_RST:   flags[FL_PGM] = 1'b1;
          CMD_COMP_RST: begin
            flags[FL_PGM] = 1'b1;
            flags[FL_ACC] = 1'b1;
            flags[FL_ERR] = 1'b1;
          end
          CMD_ACC_RST:   flags[FL_ACC] = 1'b1;
          CMD_ERR_RST:   flags[FL_ERR] = 1'b1;
          CMD_ESR_RST:   flags[FL_ESR] = 1'b1;
          CMD_CONSOLE:   flags[FL_CONSOLE] = 1'b1;
          default: ;
        endcase
      end
    end else if (seq_st == ST_XK1) begin
      lines[LN_XFER] = 1'b1;
      seq_st = ST_XK2;
    end else if (seq_st == ST_XK2) begin
      lines[LN_XFER] = 1'b0;
      seq_st = ST_IDLE;
      seqs_done++;
    end else if (seq_st > ST_LAST) begin
      seq_st = ST_IDLE;
    end else begin
      if (seq_st >= ST_PS) begin
        grp  = GRP_START;
        base = ST_PS;
      end else begin
        grp  = 3'((seq_st - 5'd1) / 5'd3);
        base = 5'(1 + 3 * grp);
      end
      stage = 2'(seq_st - base);
      case (grp)
        GRP_PGM: ln = LN_PGM;
        GRP_ACC: ln = LN_ACC;
        GRP_ERR: ln = LN_ERR;
        GRP_ESR: ln = LN_ESR;
        default: ln = LN_START;
      endcase
      // Program and accumulator resets may only end in the lower word.
      lower_end = (grp == GRP_PGM) || (grp == GRP_ACC);
      if (stage == 2'd0) begin
        if (it.dt == DT_TEN && it.upper) begin
          lines[ln] = 1'b1;
          if (grp == GRP_PGM) begin
            ctl = sw_pos[3:2];
            if (ctl == CTRL_ADDR_STOP || ctl == CTRL_RUN) lines[LN_S8000] = 1'b1;
            else lines[LN_R0000] = 1'b1;
          end
          seq_st = seq_st + 5'd1;
        end
      end else if (stage == 2'd1) begin
        if (it.dt == DT_GAP && !it.upper) seq_st = seq_st + 5'd1;
      end else begin
        if (it.dt == DT_GAP && (!lower_end || !it.upper)) begin
          lines[ln] = 1'b0;
          if (grp == GRP_PGM) begin
            lines[LN_S8000] = 1'b0;
            lines[LN_R0000] = 1'b0;
          end
          seq_st = ST_IDLE;
          seqs_done++;
        end
      end
    end

    v = '0;
    v.busy  = lines[LN_BUSY];
    v.rst   = {lines[LN_R0000], lines[LN_S8000], lines[LN_ACC],
               lines[LN_PGM], lines[LN_ESR], lines[LN_ERR]};
    v.start = lines[LN_START];
    v.xfer  = lines[LN_XFER];
    v.addr  = addr_sel;
    dsp = sw_pos[6:4];
    ctl = sw_pos[3:2];
    v.sw[0]  = !sw_pos[0];
    v.sw[1]  = sw_pos[0];
    v.sw[2]  = !sw_pos[1];
    v.sw[3]  = sw_pos[1];
    v.sw[4]  = ctl == CTRL_ADDR_STOP;
    v.sw[5]  = ctl == CTRL_RUN;
    v.sw[6]  = ctl == CTRL_MANUAL;
    v.sw[7]  = !sw_pos[7];
    v.sw[8]  = sw_pos[7];
    v.sw[9]  = !sw_pos[8];
    v.sw[10] = sw_pos[8];
    if (dsp <= DISP_READ_OUT) v.sw[11 + int'(dsp)] = 1'b1;
    v.sw[17] = dsp == DISP_READ_IN;
    v.sw[18] = dsp == DISP_READ_OUT;
    v.sw[19] = dsp != DISP_READ_IN;
    v.sw[20] = dsp <= DISP_PGM_REG;
    if (it.dt == DT_SIGN) v.digit = {3'b000, entry_w[40]};
    else if (int'(it.dt) <= ENTRY_DIGITS) v.digit = entry_w[4 * (int'(it.dt) - 1) +: 4];
  endtask

  // Next digit time of the drum: 0..10, then x, then the other word of the pair.
  function automatic console_item_t drum_item();
    console_item_t it;
    it = '0;
    it.dt    = drum_dt;
    it.upper = drum_upper;
    if (drum_dt == DT_GAP) begin
      drum_dt    = DT_SIGN;
      drum_upper = !drum_upper;
    end else begin
      drum_dt = drum_dt + 4'd1;
    end
    return it;
  endfunction

  function automatic dir_row_t mk(input logic wait_rdy, input logic drum, input logic [3:0] dt,
                                  input logic up, input logic rr, input logic [4:0] cmd,
                                  input logic [2:0] setting, input logic [39:0] opd,
                                  input logic sign);
    dir_row_t r;
    r = '0;
    r.wait_rdy     = wait_rdy;
    r.drum         = drum;
    r.item.dt      = dt;
    r.item.upper   = up;
    r.item.restart = rr;
    r.item.cmd     = cmd;
    r.item.setting = setting;
    r.item.opd     = opd;
    r.item.sign    = sign;
    return r;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Hands one item to the block, records what it must show, then paces the next one.
  task automatic send_item(input console_item_t it, input logic typed,
                           input console_view_t typed_view);
    console_view_t view;
    int unsigned   gap;
    console_step(it, view);
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    do @(posedge clk); while (!in_tready);
    views_due.insert(views_due.size(), typed ? typed_view : view);
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 30) : $urandom_range(50, 300);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: the stall pattern changes with bits 9:8 of a free-running cycle counter.
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    case (rx_cyc[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      2'd2: out_tready <= (rx_cyc % 7) >= 2;
      default: begin
        if (rx_stall != 0) begin
          rx_stall   <= rx_stall - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 9) == 0) rx_stall <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    console_view_t got;
    console_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (views_due.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS) $display("unexpected result item %h", out_tdata);
      end else begin
        want = views_due.pop_front();
        views_checked++;
        if (got !== want) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("mismatch %0d at item %0d: want busy %0b rst %02h start %0b xfer %0b",
                     fails, views_checked, want.busy, want.rst, want.start, want.xfer);
            $display("  sw %06h addr %04h digit %0h pad %0h", want.sw, want.addr,
                     want.digit, want.pad);
            $display("  got busy %0b rst %02h start %0b xfer %0b sw %06h addr %04h",
                     got.busy, got.rst, got.start, got.xfer, got.sw, got.addr);
            $display("  digit %0h pad %0h", got.digit, got.pad);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, views_due.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    console_item_t it;
    console_item_t step;
    console_view_t no_view;
    int unsigned   n;
    no_view = '0;
    console_power_on();

    add_row(mk(1'b0, 1'b1, DT_SIGN, 1'b0, 1'b0, CMD_NONE, SET_OFF, '0, 1'b0));
    dir_rows[0].typed = 1'b1;
    dir_rows[0].view  = '{pad: '0, digit: 4'd0, addr: ADDR_RESET, sw: 21'h181299,
                          xfer: 1'b0, start: 1'b0, rst: 6'd0, busy: 1'b1};
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_SW_CTRL, 3'(CTRL_MANUAL), '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_XFER_KEY, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_SW_DISP, DISP_READ_OUT, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_SW_DISP, SET_BAD, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_SW_PGM, SET_ON, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_SW_HALF, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_SW_OVFL, SET_ON, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_SW_ERR, SET_ON, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_ENTRY, SET_BAD, '1, 1'b1));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_ADDR, SET_OFF,
               40'h99_9999_9999, 1'b1));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_START_KEY, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_STOP_KEY, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_SW_CTRL, 3'(CTRL_RUN), '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_PGM_RST, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_SW_CTRL, SET_CTRL_BAD, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_SW_CTRL, 3'(CTRL_MANUAL), '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_PGM_RST, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_ACC_RST, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_ERR_RST, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_ESR_RST, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_COMP_RST, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_CONSOLE, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_XFER_KEY, SET_OFF, '0, 1'b0));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b0, CMD_UNUSED, SET_BAD, '1, 1'b1));
    add_row(mk(1'b1, 1'b1, '0, 1'b0, 1'b1, CMD_NONE, SET_OFF, '0, 1'b0));
    add_row(mk(1'b0, 1'b0, 4'd15, 1'b1, 1'b0, CMD_ENTRY, SET_OFF, '0, 1'b0));
    add_row(mk(1'b0, 1'b0, 4'd12, 1'b0, 1'b0, CMD_NONE, SET_OFF, '0, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Rows that wait for an idle console are preceded by plain digit times.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wait_rdy) begin
        while (!console_idle()) send_item(drum_item(), 1'b0, no_view);
      end
      it = dir_rows[i].item;
      if (dir_rows[i].drum) begin
        step     = drum_item();
        it.dt    = step.dt;
        it.upper = step.upper;
      end
      send_item(it, dir_rows[i].typed, dir_rows[i].view);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        in_tvalid <= 1'b0;
        while (views_due.size() != 0) @(posedge clk);
      end
      it = drum_item();
      it.opd  = 40'({$urandom(), $urandom()});
      it.sign = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 15) begin
        // Noise: any digit time, any word, any command code.
        it.dt      = 4'($urandom_range(0, 15));
        it.upper   = 1'($urandom_range(0, 1));
        it.cmd     = 5'($urandom_range(0, 31));
        it.setting = 3'($urandom_range(0, 7));
        it.restart = $urandom_range(0, 9) == 0;
      end else begin
        if ($urandom_range(0, 99) < 30) it.cmd = 5'($urandom_range(CMD_SW_PGM, CMD_CONSOLE));
        it.setting = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(0, 5));
        it.restart = $urandom_range(0, 199) == 0;
      end
      send_item(it, 1'b0, no_view);
    end

    in_tvalid <= 1'b0;
    while (views_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items (%0d directed rows), checked %0d results", items_sent,
             dir_rows.size(), views_checked);
    $display("console ran %0d commands and finished %0d line sequences", cmds_run, seqs_done);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
